// ===== hw/rtl/pps_pkg.sv =====
`timescale 1ns / 1ps
package pps_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic ACT_ARRIVE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	localparam logic [15:0] TIME_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_ACCEPTED   = 3'd0,
		ST_FULL       = 3'd1,
		ST_ZERO_BURST = 3'd2,
		ST_RAN        = 3'd3,
		ST_IDLE       = 3'd4
	} pps_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_HEAD_CHK,
		S_DEL_RD,
		S_DEL_WR,
		S_RESP
	} pps_state_t;

	// one ready-queue slot, 64 bits
	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  prio;
		logic [15:0] rem;
		logic [15:0] orig;
		logic [15:0] arr;
	} pps_entry_t;

	typedef struct packed {
		pps_status_t status;
		logic [7:0]  running_id;
		logic        finished;
		logic [15:0] finish_time;
		logic [15:0] turnaround;
		logic [15:0] waiting;
	} pps_res_t;

	function automatic logic [15:0] sat_sub16(input logic [15:0] a, input logic [15:0] b);
		sat_sub16 = (a > b) ? (a - b) : 16'd0;
	endfunction

endpackage

// ===== hw/rtl/pps_req_if.sv =====
`timescale 1ns / 1ps
interface pps_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  process_id;
	logic [7:0]  priority_req;
	logic [15:0] burst;

	modport source (output valid, action, process_id, priority_req, burst, input ready);
	modport sink (input valid, action, process_id, priority_req, burst, output ready);
endinterface

// ===== hw/rtl/pps_rsp_if.sv =====
`timescale 1ns / 1ps
interface pps_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  running_id;
	logic        finished;
	logic [15:0] finish_time;
	logic [15:0] turnaround;
	logic [15:0] waiting;

	modport source (output valid, status, running_id, finished, finish_time, turnaround,
		waiting, input ready);
	modport sink (input valid, status, running_id, finished, finish_time, turnaround,
		waiting, output ready);
endinterface

// ===== hw/rtl/pps_ram.sv =====
`timescale 1ns / 1ps
module pps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/pps_seq.sv =====
`timescale 1ns / 1ps
module pps_seq #(
	parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEF,
	localparam int AW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	pps_req_if.sink          req,
	output logic             res_valid,
	input  logic             res_ready,
	output pps_pkg::pps_res_t res,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output logic [63:0]      mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr,
	input  logic [63:0]      mem_rdata
);
	import pps_pkg::*;

	pps_state_t  state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_m1;
	logic [15:0] time_q;
	logic [7:0]  pid_q;
	logic [7:0]  prio_q;
	logic [15:0] burst_q;
	pps_res_t    res_q;
	pps_res_t    res_take;
	pps_res_t    res_head;
	pps_entry_t  rd_ent;
	pps_entry_t  new_ent;
	pps_entry_t  head_upd;
	logic [15:0] head_rem;
	logic [15:0] head_tat;
	logic        take;
	logic        cnt_zero;
	logic        cnt_full;
	logic        shift_up;

	assign req.ready = (state_q == S_IDLE);
	assign take      = req.valid && req.ready;
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	assign idx_m1   = idx_q - 1'b1;
	assign cnt_zero = (cnt_q == '0);
	assign cnt_full = (cnt_q == CW'(QUEUE_DEPTH));
	assign rd_ent   = pps_entry_t'(mem_rdata);
	assign shift_up = (rd_ent.prio > prio_q);

	assign new_ent = '{id: pid_q, prio: prio_q, rem: burst_q, orig: burst_q, arr: time_q};
	assign head_rem = (rd_ent.rem != 16'd0) ? (rd_ent.rem - 16'd1) : 16'd0;
	assign head_tat = sat_sub16(time_q, rd_ent.arr);

	always_comb begin
		head_upd     = rd_ent;
		head_upd.rem = head_rem;
	end

	// result as known at accept time
	always_comb begin
		res_take = '0;
		if (req.action == ACT_TICK) begin
			res_take.status = cnt_zero ? ST_IDLE : ST_RAN;
		end else if (req.burst == 16'd0) begin
			res_take.status = ST_ZERO_BURST;
		end else if (cnt_full) begin
			res_take.status = ST_FULL;
		end else begin
			res_take.status = ST_ACCEPTED;
		end
	end

	// result once the head has been read
	always_comb begin
		res_head            = res_q;
		res_head.running_id = rd_ent.id;
		if (head_rem == 16'd0) begin
			res_head.finished    = 1'b1;
			res_head.finish_time = time_q;
			res_head.turnaround  = head_tat;
			res_head.waiting     = sat_sub16(head_tat, rd_ent.orig);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					if (req.action == ACT_TICK) begin
						state_d = cnt_zero ? S_RESP : S_HEAD_CHK;
					end else if (req.burst == 16'd0 || cnt_full) begin
						state_d = S_RESP;
					end else begin
						state_d = S_INS_RD;
					end
				end
			end
			S_INS_RD:   state_d = (idx_q == '0) ? S_RESP : S_INS_CHK;
			S_INS_CHK:  state_d = shift_up ? S_INS_RD : S_RESP;
			S_HEAD_CHK: state_d = (head_rem == 16'd0) ? S_DEL_RD : S_RESP;
			S_DEL_RD:   state_d = (idx_q >= cnt_q) ? S_RESP : S_DEL_WR;
			S_DEL_WR:   state_d = S_DEL_RD;
			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = new_ent;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				mem_re = take && (req.action == ACT_TICK) && !cnt_zero;
			end
			S_INS_RD: begin
				if (idx_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_m1[AW-1:0];
				end
			end
			S_INS_CHK: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[AW-1:0];
				mem_wdata = shift_up ? rd_ent : new_ent;
			end
			S_HEAD_CHK: begin
				mem_we    = (head_rem != 16'd0);
				mem_wdata = head_upd;
			end
			S_DEL_RD: begin
				mem_re    = (idx_q < cnt_q);
				mem_raddr = idx_q[AW-1:0];
			end
			S_DEL_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_m1[AW-1:0];
				mem_wdata = rd_ent;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			time_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (req.action == ACT_TICK) begin
							if (time_q != TIME_MAX) begin
								time_q <= time_q + 16'd1;
							end
							idx_q <= CW'(1);
						end else begin
							idx_q <= cnt_q;
						end
					end
				end
				S_INS_RD: begin
					if (idx_q == '0) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_INS_CHK: begin
					if (shift_up) begin
						idx_q <= idx_m1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DEL_RD: begin
					if (idx_q >= cnt_q) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DEL_WR: idx_q <= idx_q + 1'b1;
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (take) begin
					pid_q   <= req.process_id;
					prio_q  <= req.priority_req;
					burst_q <= req.burst;
					res_q   <= res_take;
				end
			end
			S_HEAD_CHK: begin
				res_q <= res_head;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		time_q >= $past(time_q))
		else $error("time went backwards");

	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		take && req.action == ACT_TICK && time_q != TIME_MAX |=> time_q == $past(time_q) + 16'd1)
		else $error("tick did not advance time");

	a_fin_ran: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_q.finished |-> res_q.status == ST_RAN)
		else $error("finish reported without a run");

	a_fin_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HEAD_CHK && head_rem == 16'd0 |-> !mem_we)
		else $error("finished head written back");

endmodule

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// Preemptive priority scheduler.
// Channels: req (sink) carries one word per event: action 0 inserts a process
// (process_id, priority_req, burst) into the ready queue, action 1 is one time
// tick. rsp (source) returns exactly one word per req word, in order: status,
// running_id, finished, finish_time, turnaround, waiting.
// The ready queue lives in a single-port-write, registered-read RAM of
// QUEUE_DEPTH x 64 bits, kept sorted by priority (ties in arrival order).
// Paths from req accept to rsp valid (each memory step is read then write):
//   rejected arrival or idle tick: straight to the result
//   arrival: each entry with a worse priority moves up one slot, then the
//   new entry is written in the freed slot
//   tick that does not finish: the head is read and written back
//   tick that finishes: the head is read, then the queue shifts down
// One event is worked at a time; the walk over RAM entries sets the rate,
// and req is not ready again until the result has left the sequencer.
// rsp sits in an output register: a new req word is taken while an earlier
// result waits there; if rsp stalls, the next result holds in the sequencer
// and req is not ready until the output register frees.
// Reset clears the queue count, the time and all valid flags; no RAM clearing
// pass is needed since only entries below the count are ever read.
module preemptive_priority_scheduler #(
	parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pps_req_if.sink   req,
	pps_rsp_if.source rsp
);
	import pps_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	// sequencer to output register
	logic     res_valid;
	logic     res_ready;
	pps_res_t res;

	// RAM port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [63:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [63:0]   mem_rdata;

	// output register
	logic     out_valid_q;
	pps_res_t out_q;

	pps_ram #(
		.WIDTH ($bits(pps_entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pps_seq #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// register takes a new result when empty or being drained this cycle
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.running_id  = out_q.running_id;
	assign rsp.finished    = out_q.finished;
	assign rsp.finish_time = out_q.finish_time;
	assign rsp.turnaround  = out_q.turnaround;
	assign rsp.waiting     = out_q.waiting;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |-> !res_ready)
		else $error("pending result would be overwritten");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_RAN |-> out_q.running_id == 8'd0 && !out_q.finished)
		else $error("run fields set on a non-run result");

	a_fin_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.finished |-> out_q.turnaround <= out_q.finish_time)
		else $error("turnaround exceeds finish time");

endmodule

// ===== verif/pps_sched_checker.sv =====
`timescale 1ns / 1ps
module pps_sched_checker
	import pps_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pps_req_if   req,
	pps_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	// shadow of the ready queue, kept sorted like the block's RAM
	pps_entry_t  ready_model[$];
	logic [15:0] clock_now = '0;
	pps_res_t    result_fifo[$];
	int          mismatch_count = 0;

	assign fail_count = mismatch_count;

	function automatic pps_res_t schedule_event(input logic act, input logic [7:0] pid,
		input logic [7:0] prio, input logic [15:0] burst);
		pps_res_t   r;
		pps_entry_t e;
		int         pos;
		r = '0;
		if (act == ACT_ARRIVE) begin
			if (burst == 16'd0) begin
				r.status = ST_ZERO_BURST;
			end else if (ready_model.size() >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// behind every entry of equal or better priority
				pos = 0;
				while (pos < ready_model.size() && ready_model[pos].prio <= prio)
					pos++;
				e.id   = pid;
				e.prio = prio;
				e.rem  = burst;
				e.orig = burst;
				e.arr  = clock_now;
				ready_model.insert(pos, e);
				r.status = ST_ACCEPTED;
			end
		end else begin
			if (clock_now != TIME_MAX)
				clock_now = clock_now + 16'd1;
			if (ready_model.size() == 0) begin
				r.status = ST_IDLE;
			end else begin
				e = ready_model[0];
				r.status     = ST_RAN;
				r.running_id = e.id;
				if (e.rem <= 16'd1) begin
					r.finished    = 1'b1;
					r.finish_time = clock_now;
					r.turnaround  = (clock_now > e.arr) ? clock_now - e.arr : 16'd0;
					r.waiting     = (r.turnaround > e.orig) ? r.turnaround - e.orig : 16'd0;
					void'(ready_model.pop_front());
				end else begin
					e.rem = e.rem - 16'd1;
					ready_model[0] = e;
				end
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pps_res_t want;
		if (!arst_n) begin
			ready_model.delete();
			result_fifo.delete();
			clock_now = '0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (result_fifo.size() == 0) begin
					$error("result word with nothing outstanding (status %0d)", rsp.status);
					mismatch_count++;
				end else begin
					want = result_fifo.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("running_id", want.running_id, rsp.running_id);
					check_field("finished", want.finished, rsp.finished);
					check_field("finish_time", want.finish_time, rsp.finish_time);
					check_field("turnaround", want.turnaround, rsp.turnaround);
					check_field("waiting", want.waiting, rsp.waiting);
				end
			end
			if (req.valid && req.ready)
				result_fifo.push_back(schedule_event(req.action, req.process_id,
					req.priority_req, req.burst));
			pending <= result_fifo.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import pps_pkg::*;

	localparam int DEPTH        = QUEUE_DEPTH_DEF;
	localparam int RANDOM_WORDS = 600;
	localparam int CALM_WORDS   = 100;     // tail of the random part without idling

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   quiet = 1'b0;                    // set: no idling on either side
	int   fail_count;
	int   pending;
	int unsigned hold_left = 0;

	pps_req_if req_ch();
	pps_rsp_if rsp_ch();

	preemptive_priority_scheduler #(.QUEUE_DEPTH(DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	pps_sched_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side back-pressure: random stalls, none once quiet.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			hold_left = $urandom_range(0, 6);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Present one word and hold it until the block takes it. Valid stays high
	// into the next word unless a random gap follows.
	task automatic send_word(input logic act, input logic [7:0] pid, input logic [7:0] prio,
		input logic [15:0] burst);
		req_ch.valid        <= 1'b1;
		req_ch.action       <= act;
		req_ch.process_id   <= pid;
		req_ch.priority_req <= prio;
		req_ch.burst        <= burst;
		do @(posedge clk); while (!req_ch.ready);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic tick();
		send_word(ACT_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
	endtask

	// Stop sending and let every outstanding result come back. The first edge
	// lets the checker's count catch up with a word accepted just now.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int          episode_left;
		int unsigned arrive_pct;
		logic [7:0]  pid;
		logic [7:0]  prio;
		logic [15:0] burst;

		req_ch.valid        <= 1'b0;
		req_ch.action       <= ACT_ARRIVE;
		req_ch.process_id   <= '0;
		req_ch.priority_req <= '0;
		req_ch.burst        <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		tick();                                    // empty queue: idle, time still moves
		send_word(ACT_ARRIVE, 8'h00, 8'h00, 16'h0000);   // zero burst
		send_word(ACT_ARRIVE, 8'hFF, 8'hFF, 16'h0000);   // zero burst, other fields all ones
		send_word(ACT_ARRIVE, 8'h11, 8'd5, 16'd2);
		send_word(ACT_ARRIVE, 8'h22, 8'd5, 16'd1);       // same priority: goes behind 0x11
		send_word(ACT_ARRIVE, 8'h33, 8'd2, 16'd1);       // better priority: jumps ahead
		tick();                                    // 0x33 runs and finishes
		tick();                                    // 0x11 runs, one unit left
		// fill the remaining 14 slots; the last one has the worst priority and
		// the longest burst so it parks at the tail
		for (int k = 0; k < 14; k++)
			send_word(ACT_ARRIVE, 8'h80 + 8'(k), (k == 13) ? 8'hFF : 8'(k * 19),
				(k == 13) ? 16'hFFFF : 16'(k + 1));
		send_word(ACT_ARRIVE, 8'h55, 8'd0, 16'd1);       // queue full
		tick();                                    // priority-0 arrival 0x80 preempts, finishes

		// --- random ---
		// Episodes with an arrival-heavy, balanced or tick-heavy mix, so the
		// queue swings between full and empty. Priorities mostly come from a
		// narrow range to get plenty of ties; long bursts get poor priorities
		// so they rarely block the head.
		episode_left = 0;
		arrive_pct = 50;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2)
				wait_drained();
			if (n == RANDOM_WORDS - CALM_WORDS)
				quiet = 1'b1;
			if (episode_left == 0) begin
				episode_left = $urandom_range(10, 60);
				case ($urandom_range(0, 2))
					0: arrive_pct = 20;
					1: arrive_pct = 50;
					default: arrive_pct = 85;
				endcase
			end
			episode_left--;
			if ($urandom_range(0, 99) < arrive_pct) begin
				pid  = 8'($urandom);
				prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
				case ($urandom_range(0, 19))
					0: burst = 16'd0;
					1: begin
						burst = 16'($urandom);
						prio  = 8'($urandom_range(240, 255));
					end
					default: burst = 16'($urandom_range(1, 6));
				endcase
				send_word(ACT_ARRIVE, pid, prio, burst);
			end else begin
				tick();
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
